// ===== src/ffsa_pkg.sv =====
`timescale 1ns / 1ps

package ffsa_pkg;

	localparam int ADDR_BITS = 20;
	localparam int KIB_W     = 11;

	localparam logic [KIB_W-1:0] KIB_MIN   = 11'd1;
	localparam logic [KIB_W-1:0] KIB_MAX   = 11'd1024;
	localparam logic [KIB_W-1:0] KIB_RESET = 11'd64;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	typedef enum logic [2:0] {
		ST_ALLOCATED = 3'd0,
		ST_NO_FIT    = 3'd1,
		ST_FREED     = 3'd2,
		ST_NULL      = 3'd3,
		ST_UNKNOWN   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_WALK,
		S_SPLIT,
		S_FSCAN
	} state_t;

	typedef struct packed {
		logic                 func;
		logic [ADDR_BITS-1:0] alloc_size;
		logic [ADDR_BITS-1:0] free_addr;
	} req_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] addr;
		status_t              status;
	} rsp_t;

endpackage

// ===== src/ffsa_ram.sv =====
`timescale 1ns / 1ps

module ffsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/first_fit_segment_allocator.sv =====
`timescale 1ns / 1ps

// First-fit segment allocator. One request at a time: start is taken while busy
// is low, and the answer appears on result with done high for exactly one
// cycle; the receiver cannot stall it. The segment table sits in one RAM with a
// registered read, so timing is set by one RAM read per segment visited. An
// allocate walks the chain segments up to the fit (at most MAX_SEGMENTS) and,
// when the segment is split, goes on to S_SPLIT to write the free tail. A free
// compares entries in table order up to the match. A free of offset 0 is
// answered from idle with no table read. After reset the block builds the
// table in S_INIT, with busy high, before it drops busy. Writing cfg_wdata
// rebuilds the table as one free segment; write it only while idle.
module first_fit_segment_allocator #(
	parameter int MAX_SEGMENTS = 64,
	parameter int HEADER_BYTES = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  ffsa_pkg::req_t                request,
	output logic                          done,
	output ffsa_pkg::rsp_t                result,
	input  logic                          cfg_we,
	input  logic [ffsa_pkg::KIB_W-1:0]    cfg_wdata
);

	import ffsa_pkg::*;

	localparam int AW = ADDR_BITS;
	localparam int IW = $clog2(MAX_SEGMENTS);
	localparam int NW = $clog2(MAX_SEGMENTS + 1);
	localparam logic [NW-1:0] END_MARK = NW'(MAX_SEGMENTS);
	localparam logic [AW-1:0] HDR = AW'(HEADER_BYTES);
	localparam logic [AW:0] LIMIT = (AW + 1)'(1) << AW;

	typedef struct packed {
		logic [AW-1:0] start;
		logic [AW-1:0] size;
		logic          free;
		logic [NW-1:0] nxt;
	} entry_t;

	localparam int EW = $bits(entry_t);

	function automatic logic [AW-1:0] region_payload(input logic [KIB_W-1:0] kib);
		logic [KIB_W-1:0] k;
		logic [AW:0]      bytes;
		k = kib;
		if (k < KIB_MIN) begin
			k = KIB_MIN;
		end
		if (k > KIB_MAX) begin
			k = KIB_MAX;
		end
		bytes = (AW + 1)'({k, 10'd0});
		if (bytes > LIMIT) begin
			bytes = LIMIT;
		end
		if (bytes > {1'b0, HDR}) begin
			return AW'(bytes - {1'b0, HDR});
		end
		return '0;
	endfunction

	state_t         state_q, state_d;
	logic [NW-1:0]  used_q, used_d;
	logic [IW-1:0]  cur_q, cur_d;
	logic [AW-1:0]  req_q;
	logic [AW-1:0]  faddr_q;
	entry_t         split_q, split_d;
	rsp_t           result_q, result_d;
	logic           done_q, done_d;

	logic           ram_we;
	logic [IW-1:0]  ram_waddr;
	entry_t         ram_wdata;
	logic [IW-1:0]  ram_raddr;
	logic [EW-1:0]  ram_rdata;
	entry_t         rd;

	logic [AW:0]    need;
	logic [AW-1:0]  remaining;
	logic           fit;
	logic           do_split;
	logic           match;
	logic [NW-1:0]  cur_inc;

	ffsa_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_SEGMENTS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd = entry_t'(ram_rdata);

	assign need      = {1'b0, req_q} + {1'b0, HDR};
	assign fit       = rd.free && ({1'b0, rd.size} >= need);
	assign remaining = rd.size - req_q;
	assign do_split  = ({1'b0, remaining} > need) && (used_q < END_MARK);
	assign match     = ({1'b0, rd.start} + {1'b0, HDR}) == {1'b0, faddr_q};
	assign cur_inc   = NW'(cur_q) + NW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			used_q  <= NW'(1);
			cur_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			used_q  <= used_d;
			cur_q   <= cur_d;
			done_q  <= done_d;
		end
	end

	// request operands and result payload
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_q   <= request.alloc_size;
			faddr_q <= request.free_addr;
		end
		split_q  <= split_d;
		result_q <= result_d;
	end

	always_comb begin
		state_d   = state_q;
		used_d    = used_q;
		cur_d     = cur_q;
		split_d   = split_q;
		result_d  = result_q;
		done_d    = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = cur_q;
		ram_wdata = rd;
		ram_raddr = '0;

		case (state_q)
			S_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				ram_wdata = '{start: '0, size: region_payload(KIB_RESET), free: 1'b1,
					nxt: END_MARK};
				used_d    = NW'(1);
				state_d   = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cur_d = '0;
					if (request.func == FUNC_FREE) begin
						if (request.free_addr == '0) begin
							done_d   = 1'b1;
							result_d = '{addr: '0, status: ST_NULL};
						end else begin
							state_d = S_FSCAN;
						end
					end else begin
						state_d = S_WALK;
					end
				end
			end
			S_WALK: begin
				if (fit) begin
					ram_we   = 1'b1;
					result_d = '{addr: rd.start + HDR, status: ST_ALLOCATED};
					split_d  = '{start: rd.start + HDR + req_q, size: remaining - HDR,
						free: 1'b1, nxt: rd.nxt};
					if (do_split) begin
						ram_wdata = '{start: rd.start, size: req_q, free: 1'b0, nxt: used_q};
						state_d   = S_SPLIT;
					end else begin
						ram_wdata      = rd;
						ram_wdata.free = 1'b0;
						done_d         = 1'b1;
						state_d        = S_IDLE;
					end
				end else if (rd.nxt >= used_q) begin
					done_d   = 1'b1;
					result_d = '{addr: '0, status: ST_NO_FIT};
					state_d  = S_IDLE;
				end else begin
					ram_raddr = rd.nxt[IW-1:0];
					cur_d     = rd.nxt[IW-1:0];
				end
			end
			S_SPLIT: begin
				// new free tail goes into the first unused entry
				ram_we    = 1'b1;
				ram_waddr = used_q[IW-1:0];
				ram_wdata = split_q;
				used_d    = used_q + NW'(1);
				done_d    = 1'b1;
				state_d   = S_IDLE;
			end
			S_FSCAN: begin
				if (match) begin
					ram_we         = 1'b1;
					ram_wdata      = rd;
					ram_wdata.free = 1'b1;
					done_d         = 1'b1;
					result_d       = '{addr: '0, status: ST_FREED};
					state_d        = S_IDLE;
				end else if (cur_inc >= used_q) begin
					done_d   = 1'b1;
					result_d = '{addr: '0, status: ST_UNKNOWN};
					state_d  = S_IDLE;
				end else begin
					ram_raddr = cur_inc[IW-1:0];
					cur_d     = cur_inc[IW-1:0];
				end
			end
			default: begin
				state_d = S_INIT;
			end
		endcase

		// region write rebuilds the table; the user must do it only while idle, the block does not enforce it
		if (cfg_we) begin
			ram_we    = 1'b1;
			ram_waddr = '0;
			ram_wdata = '{start: '0, size: region_payload(cfg_wdata), free: 1'b1,
				nxt: END_MARK};
			used_d    = NW'(1);
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== tb/sv/first_fit_segment_allocator_tb.sv =====
`timescale 1ns / 1ps

module first_fit_segment_allocator_tb;
	import ffsa_pkg::*;

	localparam int SEG_SLOTS = 64;
	localparam int HDR_BYTES = 24;

	typedef struct {
		req_t req;
		bit   pick_live;	// free_addr is taken from the live table when driven
	} pending_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	req_t             request = '0;
	logic             done;
	rsp_t             result;
	logic             cfg_we = 1'b0;
	logic [KIB_W-1:0] cfg_wdata = '0;

	// segment table as the block should hold it
	int unsigned seg_start[SEG_SLOTS];
	int unsigned seg_size[SEG_SLOTS];
	bit          seg_free[SEG_SLOTS];
	int unsigned seg_next[SEG_SLOTS];
	int unsigned seg_count;
	int unsigned region_bytes;

	pending_t pending_q[$];
	rsp_t     rsp_q[$];
	int       fail_count = 0;
	bit       item_taken = 1'b0;
	bit       idle_en = 1'b1;
	int       gap_left = 0;

	first_fit_segment_allocator #(
		.MAX_SEGMENTS(SEG_SLOTS),
		.HEADER_BYTES(HDR_BYTES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic void seg_rebuild(logic [KIB_W-1:0] kib_w);
		int unsigned kib;
		kib = kib_w;
		if (kib < 1) kib = 1;
		if (kib > 1024) kib = 1024;
		region_bytes = kib * 1024;
		if (region_bytes > (1 << ADDR_BITS)) region_bytes = 1 << ADDR_BITS;
		for (int i = 0; i < SEG_SLOTS; i++) begin
			seg_start[i] = 0;
			seg_size[i] = 0;
			seg_free[i] = 1'b0;
			seg_next[i] = 0;
		end
		seg_size[0] = (region_bytes > HDR_BYTES) ? region_bytes - HDR_BYTES : 0;
		seg_free[0] = 1'b1;
		seg_next[0] = SEG_SLOTS;
		seg_count = 1;
	endfunction

	function automatic rsp_t seg_service(req_t r);
		rsp_t        o;
		int unsigned cur, steps, want, need, rem, n;
		o.addr = '0;
		if (r.func == FUNC_ALLOC) begin
			o.status = ST_NO_FIT;
			want = r.alloc_size;
			need = want + HDR_BYTES;
			cur = 0;
			steps = 0;
			while (cur < seg_count && steps < SEG_SLOTS) begin
				if (seg_free[cur] && seg_size[cur] >= need) begin
					rem = seg_size[cur] - want;
					if (rem > need && seg_count < SEG_SLOTS) begin
						n = seg_count;
						seg_start[n] = seg_start[cur] + HDR_BYTES + want;
						seg_size[n] = rem - HDR_BYTES;
						seg_free[n] = 1'b1;
						seg_next[n] = seg_next[cur];
						seg_next[cur] = n;
						seg_size[cur] = want;
						seg_count = n + 1;
					end
					// taken whole or split, the segment is used from here on
					seg_free[cur] = 1'b0;
					o.status = ST_ALLOCATED;
					o.addr = ADDR_BITS'(seg_start[cur] + HDR_BYTES);
					return o;
				end
				cur = seg_next[cur];
				steps++;
			end
		end else if (r.free_addr == '0) begin
			o.status = ST_NULL;
		end else begin
			o.status = ST_UNKNOWN;
			for (int i = 0; i < seg_count; i++) begin
				if (seg_start[i] + HDR_BYTES == r.free_addr) begin
					seg_free[i] = 1'b1;
					o.status = ST_FREED;
					break;
				end
			end
		end
		return o;
	endfunction

	// driver: one request at a time, start held until the block takes it
	always @(negedge clk) begin : drive_req
		logic     nxt_start;
		req_t     nxt_req;
		pending_t p;
		nxt_start = start;
		nxt_req = request;
		if (start && item_taken) nxt_start = 1'b0;
		if (!nxt_start) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_q.size() > 0) begin
				p = pending_q.pop_front();
				nxt_req = p.req;
				if (p.pick_live)
					nxt_req.free_addr =
						ADDR_BITS'(seg_start[$urandom_range(0, seg_count - 1)] + HDR_BYTES);
				nxt_start = 1'b1;
				if (idle_en && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 15);
			end
		end
		start <= nxt_start;
		request <= nxt_req;
	end

	// monitor: predict on acceptance, check each strobed result in order
	always @(posedge clk) begin : watch_rsp
		rsp_t want;
		if (!arst_n) begin
			item_taken <= 1'b0;
		end else begin
			if (done === 1'b1) begin
				if (rsp_q.size() == 0) begin
					$error("result with no request pending: addr %0h status %0d",
						result.addr, result.status);
					fail_count++;
				end else begin
					want = rsp_q.pop_front();
					if (result.addr !== want.addr) begin
						$error("addr: expected %0h, got %0h", want.addr, result.addr);
						fail_count++;
					end
					if (result.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, result.status);
						fail_count++;
					end
				end
			end
			if (start && busy === 1'b0) rsp_q.push_back(seg_service(request));
			item_taken <= start && busy === 1'b0;
		end
	end

	task automatic add_item(logic func, int unsigned size, int unsigned addr);
		pending_t p;
		p.req.func = func;
		p.req.alloc_size = ADDR_BITS'(size);
		p.req.free_addr = ADDR_BITS'(addr);
		p.pick_live = 1'b0;
		pending_q.push_back(p);
	endtask

	task automatic add_random(int count);
		pending_t p;
		int       roll;
		for (int k = 0; k < count; k++) begin
			roll = $urandom_range(0, 99);
			p.req.func = FUNC_ALLOC;
			p.req.alloc_size = ADDR_BITS'($urandom);
			p.req.free_addr = ADDR_BITS'($urandom);
			p.pick_live = 1'b0;
			if (roll < 45) begin
				p.req.alloc_size = ADDR_BITS'($urandom_range(0, 127));
			end else if (roll < 60) begin
				p.req.alloc_size = ADDR_BITS'($urandom_range(0, region_bytes / 8));
			end else if (roll < 65) begin
				p.req.alloc_size = ADDR_BITS'($urandom_range(0, region_bytes));
			end else if (roll < 68) begin
				// full-range size, almost always no fit
			end else if (roll < 90) begin
				p.req.func = FUNC_FREE;
				p.pick_live = 1'b1;
			end else if (roll < 93) begin
				p.req.func = FUNC_FREE;
				p.req.free_addr = '0;
			end else if (roll < 97) begin
				p.req.func = FUNC_FREE;
			end else begin
				// near-miss offsets inside the low part of the region
				p.req.func = FUNC_FREE;
				p.req.free_addr = ADDR_BITS'($urandom_range(1, 255));
			end
			pending_q.push_back(p);
		end
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (pending_q.size() != 0 || start || rsp_q.size() != 0 || busy !== 1'b0)
			@(posedge clk);
	endtask

	task automatic write_region(logic [KIB_W-1:0] kib);
		wait_drained();
		@(negedge clk);
		cfg_wdata <= kib;
		cfg_we <= 1'b1;
		seg_rebuild(kib);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		seg_rebuild(KIB_RESET);
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// default 64 KiB region: payload 65512 at offset 24
		add_item(FUNC_FREE, 20'hFFFFF, 0);
		add_item(FUNC_FREE, 0, 20'hFFFFF);
		add_item(FUNC_ALLOC, 0, 20'hFFFFF);
		add_item(FUNC_ALLOC, 20'hFFFFF, 0);
		add_item(FUNC_ALLOC, 65464, 0);		// exact fit in the tail, no split
		add_item(FUNC_ALLOC, 0, 0);
		add_item(FUNC_FREE, 0, 24);
		add_item(FUNC_FREE, 0, 24);			// already free
		add_item(FUNC_FREE, 20'hFFFFF, 72);
		add_item(FUNC_FREE, 0, 25);
		add_item(FUNC_ALLOC, 0, 0);
		add_random(60);

		write_region(11'd1);
		add_item(FUNC_ALLOC, 977, 0);
		add_item(FUNC_ALLOC, 976, 0);
		add_item(FUNC_ALLOC, 0, 0);
		add_item(FUNC_FREE, 0, 24);
		add_item(FUNC_ALLOC, 976, 0);
		add_random(40);

		write_region(11'd1024);
		add_random(130);
		write_region(11'd0);
		add_random(120);
		write_region(11'd2047);
		add_random(130);
		write_region(11'd512);
		add_random(130);
		write_region(KIB_W'($urandom_range(1, 1024)));
		add_random(130);
		write_region(11'd37);
		add_random(100);
		write_region(11'd2);
		add_random(100);

		// closing stretch runs back to back
		write_region(11'd1024);
		idle_en = 1'b0;
		add_random(110);

		wait_drained();
		repeat (80) @(posedge clk);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/ffsa_pkg.sv
src/ffsa_ram.sv
src/first_fit_segment_allocator.sv
tb/sv/first_fit_segment_allocator_tb.sv
